// ----- sv/ntbl_pkg.sv -----
// shared types, constants and the colour table for the neighbor table block
// no dependencies
package ntbl_pkg;

    localparam int TABLE_SIZE_DEF = 16;

    localparam int ID_W   = 9;
    localparam int AGE_W  = 4;
    localparam int CNT_W  = 8;
    localparam int TMR_W  = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 8;
    localparam int S_TDATA_W = 16;

    localparam logic [AGE_W-1:0] AGE_MAX      = 4'd15;
    localparam logic [CNT_W-1:0] NO_COUNT_MIN = 8'd17;
    localparam logic [TMR_W-1:0] TMR_MAX      = 8'd255;

    localparam logic [AGE_W-1:0] RST_EXPIRY      = 4'd4;
    localparam logic [TMR_W-1:0] RST_AGE_PERIOD  = 8'd32;
    localparam logic [TMR_W-1:0] RST_BLINK_OFF   = 8'd32;
    localparam logic [TMR_W-1:0] RST_BLINK_PER   = 8'd64;
    localparam logic [TMR_W-1:0] RST_MOVE_STOP   = 8'd64;
    localparam logic [TMR_W-1:0] RST_MOVE_PER    = 8'd96;
    localparam logic [TMR_W-1:0] RST_STARTUP     = 8'd96;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EXPIRY       = 3'd0,
        CFG_AGE_PERIOD   = 3'd1,
        CFG_BLINK_OFF    = 3'd2,
        CFG_BLINK_PERIOD = 3'd3,
        CFG_MOVE_STOP    = 3'd4,
        CFG_MOVE_PERIOD  = 3'd5,
        CFG_STARTUP      = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [AGE_W-1:0] expiry_threshold;
        logic [TMR_W-1:0] age_period;
        logic [TMR_W-1:0] blink_off_at;
        logic [TMR_W-1:0] blink_period;
        logic [TMR_W-1:0] move_stop_at;
        logic [TMR_W-1:0] move_period;
        logic [TMR_W-1:0] startup_delay;
    } cfg_t;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [AGE_W-1:0] age;
        logic [CNT_W-1:0] count;
    } entry_t;

    // status of the flash, led and motion unit
    typedef struct packed {
        logic       flashing;
        logic [2:0] led_color;
        logic       moving;
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_APPEND,
        ST_DECIDE,
        ST_FINISH
    } st_t;

    // white, red, yellow, green, blue, teal, purple, then off
    function automatic logic [2:0] colour_for(input logic [7:0] n);
        logic [2:0] c;
        case (n)
            8'd0:    c = 3'd7;
            8'd1:    c = 3'd4;
            8'd2:    c = 3'd6;
            8'd3:    c = 3'd2;
            8'd4:    c = 3'd1;
            8'd5:    c = 3'd3;
            8'd6:    c = 3'd5;
            default: c = 3'd0;
        endcase
        return c;
    endfunction

endpackage

// ----- sv/ntbl_mode.sv -----
// flash mode, blink and motion timers, led colour and motion state
// depends on ntbl_pkg
module ntbl_mode #(
    parameter int CW = 5
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  ntbl_pkg::cfg_t  cfg,
    input  logic          upd,
    input  logic [CW-1:0] used,
    input  logic [7:0]    smallest,
    output ntbl_pkg::mode_t status
);
    import ntbl_pkg::*;

    logic [TMR_W-1:0] blink_timer_reg, blink_timer_next;
    logic [TMR_W-1:0] move_timer_reg, move_timer_next;
    logic [TMR_W-1:0] since_reset_reg, since_reset_next;
    logic             flash_reg, flash_next;
    logic [2:0]       led_reg, led_next;
    logic             motion_reg, motion_next;

    always_comb begin
        logic [7:0] used8;
        used8 = 8'(used);
        blink_timer_next = blink_timer_reg + 8'd1;
        move_timer_next  = move_timer_reg + 8'd1;
        since_reset_next = (since_reset_reg == TMR_MAX) ? TMR_MAX : since_reset_reg + 8'd1;
        flash_next  = flash_reg;
        led_next    = led_reg;
        motion_next = motion_reg;

        if (used8 <= smallest) begin
            if (!flash_next) begin
                flash_next       = 1'b1;
                blink_timer_next = '0;
                move_timer_next  = '0;
            end
        end else begin
            flash_next = 1'b0;
        end

        if (flash_next) begin
            if (blink_timer_next == cfg.blink_off_at) begin
                led_next = 3'd0;
            end else if (blink_timer_next == cfg.blink_period) begin
                blink_timer_next = '0;
                led_next = colour_for(used8);
                if (used8 == 8'd0) motion_next = 1'b0;
            end
        end else begin
            led_next = colour_for(used8);
            if (used8 == 8'd0) motion_next = 1'b0;
        end

        if (since_reset_next > cfg.startup_delay) begin
            if (flash_next) begin
                if (move_timer_next == cfg.move_stop_at) begin
                    motion_next = 1'b0;
                end else if (move_timer_next == cfg.move_period) begin
                    if (used8 != 8'd0) motion_next = 1'b1;
                    move_timer_next = '0;
                end
            end else begin
                motion_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blink_timer_reg <= '0;
            move_timer_reg  <= '0;
            since_reset_reg <= '0;
            flash_reg       <= 1'b1;
            led_reg         <= 3'd0;
            motion_reg      <= 1'b0;
        end else if (upd) begin
            blink_timer_reg <= blink_timer_next;
            move_timer_reg  <= move_timer_next;
            since_reset_reg <= since_reset_next;
            flash_reg       <= flash_next;
            led_reg         <= led_next;
            motion_reg      <= motion_next;
        end
    end

    assign status.flashing  = flash_reg;
    assign status.led_color = led_reg;
    assign status.moving    = motion_reg;

endmodule

// ----- sv/neighbor_table_with_heartbeat_expiry.sv -----
// flow: each entry is read in ST_READ and checked in ST_CHECK; a message stops at its matching
// entry, a new sender walks every entry to ST_APPEND and a tick walks every entry to ST_DECIDE
// throughput: one word at a time; each entry of the memory is read and then checked, and the
// next word is taken in the cycle after the result register is loaded
// reset: synchronous active low, table empty, flashing on, led off, motion stopped,
// registers at their defaults; memory contents beyond the fill count are never read
module neighbor_table_with_heartbeat_expiry #(
    parameter int TABLE_SIZE = ntbl_pkg::TABLE_SIZE_DEF,
    localparam int CW      = $clog2(TABLE_SIZE + 1),
    localparam int TDATA_W = ((CW + 5 + 7) / 8) * 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ntbl_pkg::S_TDATA_W-1:0]    s_tdata,   // sender_id, sender_count
    input  logic                              s_tuser,   // func
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [TDATA_W-1:0]                m_tdata,   // neighbor_count, flashing,
                                                         // led_color, moving
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ntbl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ntbl_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import ntbl_pkg::*;

    localparam int IDX_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;

    st_t state_reg, state_next;

    cfg_t             cfg_reg;
    logic [CW-1:0]    used_reg, used_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic [CW-1:0]    kept_reg, kept_next;
    logic [CNT_W-1:0] min_reg, min_next;
    logic [TMR_W-1:0] age_timer_reg;
    logic             fire_reg;
    logic             func_reg;
    logic [ID_W-1:0]  id_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             m_tvalid_reg;
    logic [TDATA_W-1:0] m_tdata_reg;

    entry_t mem [TABLE_SIZE];
    entry_t rd_data_reg;
    logic   wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t wr_data;

    logic   s_acc;
    logic   mode_upd;
    mode_t  mode_status;
    logic   last_entry;
    logic   id_match;
    logic [AGE_W-1:0] aged;
    logic   keep;
    logic   out_free;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;

    assign last_entry = (CW'(idx_reg + CW'(1)) == used_reg);
    assign id_match   = (rd_data_reg.id == id_reg);
    assign aged       = (fire_reg && rd_data_reg.age < AGE_MAX) ?
                        rd_data_reg.age + 4'd1 : rd_data_reg.age;
    assign keep       = (aged < cfg_reg.expiry_threshold);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    if (used_reg != '0)
                        state_next = ST_READ;
                    else if (s_tuser)
                        state_next = ST_DECIDE;
                    else
                        state_next = ST_APPEND;
                end
            end
            ST_READ: state_next = ST_CHECK;
            ST_CHECK: begin
                if (!func_reg && id_match)
                    state_next = ST_FINISH;
                else if (last_entry)
                    state_next = func_reg ? ST_DECIDE : ST_APPEND;
                else
                    state_next = ST_READ;
            end
            ST_APPEND: state_next = ST_FINISH;
            ST_DECIDE: state_next = ST_FINISH;
            ST_FINISH: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath controls
    always_comb begin
        wr_en     = 1'b0;
        wr_addr   = idx_reg[IDX_W-1:0];
        wr_data   = rd_data_reg;
        idx_next  = idx_reg;
        kept_next = kept_reg;
        min_next  = min_reg;
        used_next = used_reg;
        mode_upd  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                idx_next  = '0;
                kept_next = '0;
                min_next  = NO_COUNT_MIN;
            end
            ST_CHECK: begin
                idx_next = CW'(idx_reg + CW'(1));
                if (func_reg) begin
                    // compaction: surviving entries move down to the kept position
                    if (keep) begin
                        wr_en     = 1'b1;
                        wr_addr   = kept_reg[IDX_W-1:0];
                        wr_data   = '{id: rd_data_reg.id, age: aged, count: rd_data_reg.count};
                        kept_next = CW'(kept_reg + CW'(1));
                        if (rd_data_reg.count != '0 && rd_data_reg.count < min_reg)
                            min_next = rd_data_reg.count;
                    end
                end else if (id_match) begin
                    wr_en   = 1'b1;
                    wr_data = '{id: id_reg, age: '0, count: cnt_reg};
                end
            end
            ST_APPEND: begin
                if (used_reg < CW'(TABLE_SIZE)) begin
                    wr_en     = 1'b1;
                    wr_addr   = used_reg[IDX_W-1:0];
                    wr_data   = '{id: id_reg, age: '0, count: cnt_reg};
                    used_next = CW'(used_reg + CW'(1));
                end
            end
            ST_DECIDE: begin
                used_next = kept_reg;
                mode_upd  = 1'b1;
            end
            default: ;
        endcase
    end

    // entry memory, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[idx_reg[IDX_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            age_timer_reg <= '0;
            fire_reg      <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            cfg_reg       <= '{expiry_threshold: RST_EXPIRY, age_period: RST_AGE_PERIOD,
                               blink_off_at: RST_BLINK_OFF, blink_period: RST_BLINK_PER,
                               move_stop_at: RST_MOVE_STOP, move_period: RST_MOVE_PER,
                               startup_delay: RST_STARTUP};
        end else begin
            state_reg <= state_next;
            used_reg  <= used_next;
            if (s_acc && s_tuser) begin
                logic [TMR_W-1:0] at;
                at = (age_timer_reg == TMR_MAX) ? TMR_MAX : age_timer_reg + 8'd1;
                fire_reg      <= (at >= cfg_reg.age_period);
                age_timer_reg <= (at >= cfg_reg.age_period) ? '0 : at;
            end
            if (state_reg == ST_FINISH && out_free)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
            if (cfg_valid && cfg_ready) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_EXPIRY:       cfg_reg.expiry_threshold <= cfg_data[AGE_W-1:0];
                    CFG_AGE_PERIOD:   cfg_reg.age_period       <= cfg_data;
                    CFG_BLINK_OFF:    cfg_reg.blink_off_at     <= cfg_data;
                    CFG_BLINK_PERIOD: cfg_reg.blink_period     <= cfg_data;
                    CFG_MOVE_STOP:    cfg_reg.move_stop_at     <= cfg_data;
                    CFG_MOVE_PERIOD:  cfg_reg.move_period      <= cfg_data;
                    CFG_STARTUP:      cfg_reg.startup_delay    <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg  <= idx_next;
        kept_reg <= kept_next;
        min_reg  <= min_next;
        if (s_acc) begin
            func_reg <= s_tuser;
            id_reg   <= ID_W'(s_tdata[7:0]) + 9'd1;
            cnt_reg  <= s_tdata[15:8];
        end
        if (state_reg == ST_FINISH && out_free)
            m_tdata_reg <= TDATA_W'({mode_status.moving, mode_status.led_color,
                                     mode_status.flashing, used_reg});
    end

    ntbl_mode #(
        .CW(CW)
    ) u_mode (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .upd      (mode_upd),
        .used     (kept_reg),
        .smallest (min_reg),
        .status   (mode_status)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- sv/ntbl_checker.sv -----
// port-level checks for the neighbor table block, bound to the top level
// depends on ntbl_pkg and neighbor_table_with_heartbeat_expiry
module ntbl_checker #(
    parameter int TABLE_SIZE = ntbl_pkg::TABLE_SIZE_DEF,
    localparam int CW      = $clog2(TABLE_SIZE + 1),
    localparam int TDATA_W = ((CW + 5 + 7) / 8) * 8
) (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [TDATA_W-1:0]              m_tdata
);
    import ntbl_pkg::*;

    // no result word right after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // one word in work at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second word taken while busy");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed under stall");

    // table fill never exceeds its size
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[CW-1:0] <= CW'(TABLE_SIZE)))
        else $error("neighbor count out of range");

endmodule

bind neighbor_table_with_heartbeat_expiry ntbl_checker #(
    .TABLE_SIZE(TABLE_SIZE)
) u_ntbl_checker (.*);

// ----- verif/neighbor_table_with_heartbeat_expiry_tb.sv -----
// testbench for neighbor_table_with_heartbeat_expiry: message and tick words are streamed in,
// and each status word is checked against a cycle-free model of the neighbor table
// depends on ntbl_pkg and the neighbor_table_with_heartbeat_expiry rtl
`timescale 1ns / 1ps

module neighbor_table_with_heartbeat_expiry_tb;
    import ntbl_pkg::*;

    localparam int NB_MAX      = TABLE_SIZE_DEF;
    localparam int M_TDATA_W   = 16;
    localparam int IDLE_PCT    = 31;
    localparam int RX_HOLD     = 300;
    localparam int SETTLE      = 60;
    localparam int CYCLE_LIMIT = 400000;

    localparam logic FUNC_MSG  = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    localparam logic [2:0] LED_OFF    = 3'd0;
    localparam logic [2:0] LED_BLUE   = 3'd1;
    localparam logic [2:0] LED_GREEN  = 3'd2;
    localparam logic [2:0] LED_TEAL   = 3'd3;
    localparam logic [2:0] LED_RED    = 3'd4;
    localparam logic [2:0] LED_PURPLE = 3'd5;
    localparam logic [2:0] LED_YELLOW = 3'd6;
    localparam logic [2:0] LED_WHITE  = 3'd7;

    typedef struct {
        logic [4:0] count;
        logic       flashing;
        logic [2:0] led;
        logic       moving;
    } status_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;    // sender_id, sender_count
    logic                   s_tuser;    // func
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;    // neighbor_count, flashing, led_color, moving
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    neighbor_table_with_heartbeat_expiry DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // model of the block: registers, neighbor table, timers and outputs
    logic [3:0] cf_expiry;
    logic [7:0] cf_age_period;
    logic [7:0] cf_blink_off;
    logic [7:0] cf_blink_period;
    logic [7:0] cf_move_stop;
    logic [7:0] cf_move_period;
    logic [7:0] cf_startup;

    logic [8:0] nb_id  [NB_MAX];
    logic [3:0] nb_age [NB_MAX];
    logic [7:0] nb_cnt [NB_MAX];
    int         nb_used;
    logic [7:0] age_tmr;
    logic [7:0] blink_tmr;
    logic [7:0] move_tmr;
    logic [7:0] uptime;
    logic       flash_on;
    logic [2:0] led_now;
    logic       motion_fwd;

    status_t pending_status[$];
    int      errors = 0;
    int      cycles = 0;
    int      rx_hold_req = 0;
    int      rx_hold_done;
    bit      tx_calm = 1'b0;
    bit      rx_calm = 1'b0;
    logic [7:0] id_base = 8'd0;

    function automatic logic [2:0] led_for_count(input int n);
        case (n)
            0:       return LED_WHITE;
            1:       return LED_RED;
            2:       return LED_YELLOW;
            3:       return LED_GREEN;
            4:       return LED_BLUE;
            5:       return LED_TEAL;
            6:       return LED_PURPLE;
            default: return LED_OFF;
        endcase
    endfunction

    task automatic clear_neighbor_model();
        cf_expiry       = RST_EXPIRY;
        cf_age_period   = RST_AGE_PERIOD;
        cf_blink_off    = RST_BLINK_OFF;
        cf_blink_period = RST_BLINK_PER;
        cf_move_stop    = RST_MOVE_STOP;
        cf_move_period  = RST_MOVE_PER;
        cf_startup      = RST_STARTUP;
        for (int i = 0; i < NB_MAX; i++) begin
            nb_id[i]  = '0;
            nb_age[i] = '0;
            nb_cnt[i] = '0;
        end
        nb_used    = 0;
        age_tmr    = '0;
        blink_tmr  = '0;
        move_tmr   = '0;
        uptime     = '0;
        flash_on   = 1'b1;
        led_now    = LED_OFF;
        motion_fwd = 1'b0;
    endtask

    task automatic load_register(input logic [2:0] idx, input logic [7:0] val);
        case (idx)
            CFG_EXPIRY:       cf_expiry       = val[3:0];
            CFG_AGE_PERIOD:   cf_age_period   = val;
            CFG_BLINK_OFF:    cf_blink_off    = val;
            CFG_BLINK_PERIOD: cf_blink_period = val;
            CFG_MOVE_STOP:    cf_move_stop    = val;
            CFG_MOVE_PERIOD:  cf_move_period  = val;
            CFG_STARTUP:      cf_startup      = val;
            default: ;
        endcase
    endtask

    task automatic absorb_message(input logic [7:0] sid, input logic [7:0] scnt);
        logic [8:0] key;
        bit         found;
        key   = {1'b0, sid} + 9'd1;
        found = 1'b0;
        for (int i = 0; i < nb_used; i++) begin
            if (!found && nb_id[i] == key) begin
                nb_age[i] = '0;
                nb_cnt[i] = scnt;
                found     = 1'b1;
            end
        end
        if (!found && nb_used < NB_MAX) begin
            nb_id[nb_used]  = key;
            nb_age[nb_used] = '0;
            nb_cnt[nb_used] = scnt;
            nb_used++;
        end
    endtask

    task automatic show_count_colour();
        led_now = led_for_count(nb_used);
        if (nb_used == 0)
            motion_fwd = 1'b0;
    endtask

    task automatic run_tick();
        int kept;
        int smallest;
        if (age_tmr != TMR_MAX)
            age_tmr++;
        blink_tmr++;
        move_tmr++;
        if (uptime != TMR_MAX)
            uptime++;

        if (age_tmr >= cf_age_period) begin
            for (int i = 0; i < nb_used; i++)
                if (nb_age[i] != AGE_MAX)
                    nb_age[i]++;
            age_tmr = '0;
        end

        // drop expired entries, survivors keep their order
        kept = 0;
        for (int i = 0; i < nb_used; i++) begin
            if (nb_age[i] < cf_expiry) begin
                nb_id[kept]  = nb_id[i];
                nb_age[kept] = nb_age[i];
                nb_cnt[kept] = nb_cnt[i];
                kept++;
            end
        end
        for (int i = kept; i < NB_MAX; i++) begin
            nb_id[i]  = '0;
            nb_age[i] = '0;
            nb_cnt[i] = '0;
        end
        nb_used = kept;

        smallest = NO_COUNT_MIN;
        for (int i = 0; i < nb_used; i++)
            if (nb_cnt[i] != 0 && nb_cnt[i] < smallest)
                smallest = nb_cnt[i];
        if (nb_used <= smallest) begin
            if (!flash_on) begin
                flash_on  = 1'b1;
                blink_tmr = '0;
                move_tmr  = '0;
            end
        end else begin
            flash_on = 1'b0;
        end

        if (flash_on) begin
            if (blink_tmr == cf_blink_off) begin
                led_now = LED_OFF;
            end else if (blink_tmr == cf_blink_period) begin
                blink_tmr = '0;
                show_count_colour();
            end
        end else begin
            show_count_colour();
        end

        if (uptime > cf_startup) begin
            if (flash_on) begin
                if (move_tmr == cf_move_stop) begin
                    motion_fwd = 1'b0;
                end else if (move_tmr == cf_move_period) begin
                    if (nb_used != 0)
                        motion_fwd = 1'b1;
                    move_tmr = '0;
                end
            end else begin
                motion_fwd = 1'b0;
            end
        end
    endtask

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: no progress within the cycle limit", $time);
            $display("neighbor_table_with_heartbeat_expiry test failed");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        m_tready     = 1'b0;
        rx_hold_done = 0;
        forever begin
            @(negedge aclk);
            if (rx_hold_req != rx_hold_done) begin
                m_tready = 1'b0;
                repeat (RX_HOLD - 1) @(negedge aclk);
                rx_hold_done = rx_hold_req;
            end else begin
                m_tready = rx_calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // predicts on every accepted input word and checks every accepted result word
    always @(posedge aclk) begin
        status_t want;
        status_t got;
        if (!aresetn) begin
            clear_neighbor_model();
        end else begin
            if (cfg_valid && cfg_ready)
                load_register(cfg_index, cfg_data);
            if (s_tvalid && s_tready) begin
                if (s_tuser == FUNC_TICK)
                    run_tick();
                else
                    absorb_message(s_tdata[7:0], s_tdata[15:8]);
                want.count    = 5'(nb_used);
                want.flashing = flash_on;
                want.led      = led_now;
                want.moving   = motion_fwd;
                pending_status.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got.count    = m_tdata[4:0];
                got.flashing = m_tdata[5];
                got.led      = m_tdata[8:6];
                got.moving   = m_tdata[9];
                if (pending_status.size() == 0) begin
                    errors++;
                    $display("%0t: status word with none expected: count %0d flash %0b led %0d move %0b",
                             $time, got.count, got.flashing, got.led, got.moving);
                end else begin
                    want = pending_status.pop_front();
                    if (got.count !== want.count) begin
                        errors++;
                        $display("%0t: neighbor_count expected %0d actual %0d",
                                 $time, want.count, got.count);
                    end
                    if (got.flashing !== want.flashing) begin
                        errors++;
                        $display("%0t: flashing expected %0b actual %0b",
                                 $time, want.flashing, got.flashing);
                    end
                    if (got.led !== want.led) begin
                        errors++;
                        $display("%0t: led_color expected %0d actual %0d",
                                 $time, want.led, got.led);
                    end
                    if (got.moving !== want.moving) begin
                        errors++;
                        $display("%0t: moving expected %0b actual %0b",
                                 $time, want.moving, got.moving);
                    end
                end
            end
        end
    end

    // valid stays high after a word is taken; the next call replaces or lowers it
    task automatic send_word(input logic f, input logic [7:0] sid, input logic [7:0] scnt);
        @(negedge aclk);
        while (!tx_calm && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = f;
        s_tdata  = {scnt, sid};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic sender_rest();
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic wait_drained();
        sender_rest();
        while (pending_status.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [7:0] val);
        wait_drained();
        repeat (SETTLE) @(posedge aclk);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic write_all_regs(input logic [3:0] ex, input logic [7:0] ap,
                                  input logic [7:0] bo, input logic [7:0] bp,
                                  input logic [7:0] ms, input logic [7:0] mp,
                                  input logic [7:0] su);
        write_reg(CFG_EXPIRY, {4'd0, ex});
        write_reg(CFG_AGE_PERIOD, ap);
        write_reg(CFG_BLINK_OFF, bo);
        write_reg(CFG_BLINK_PERIOD, bp);
        write_reg(CFG_MOVE_STOP, ms);
        write_reg(CFG_MOVE_PERIOD, mp);
        write_reg(CFG_STARTUP, su);
    endtask

    // mostly a small pool of senders with small counts, so entries match, fill and expire
    task automatic send_random_word(input int tick_pct);
        logic       f;
        logic [7:0] sid;
        logic [7:0] scnt;
        if ($urandom_range(99) < 70) begin
            f    = ($urandom_range(99) < tick_pct) ? FUNC_TICK : FUNC_MSG;
            sid  = id_base + 8'($urandom_range(19));
            scnt = 8'($urandom_range(20));
        end else begin
            f    = $urandom_range(1) ? FUNC_TICK : FUNC_MSG;
            sid  = 8'($urandom);
            scnt = 8'($urandom);
        end
        send_word(f, sid, scnt);
    endtask

    task automatic test_basic_words();
        send_word(FUNC_TICK, 8'hFF, 8'hFF);
        send_word(FUNC_MSG, 8'd0, 8'd0);
        send_word(FUNC_MSG, 8'd255, 8'd255);
        send_word(FUNC_MSG, 8'd0, 8'd7);
        send_word(FUNC_TICK, 8'd0, 8'd0);
    endtask

    // fill to capacity, then a new sender is dropped and a known one refreshed
    task automatic test_table_full();
        write_reg(CFG_EXPIRY, 8'd15);
        write_reg(CFG_AGE_PERIOD, 8'd255);
        for (int k = 1; k <= 14; k++)
            send_word(FUNC_MSG, 8'(k), 8'(k));
        send_word(FUNC_MSG, 8'd200, 8'd1);
        send_word(FUNC_MSG, 8'd5, 8'd0);
        send_word(FUNC_TICK, 8'd0, 8'd0);
    endtask

    // zero threshold and zero period: everything ages and expires at once
    task automatic test_instant_expiry();
        write_reg(CFG_EXPIRY, 8'd0);
        write_reg(CFG_AGE_PERIOD, 8'd0);
        send_word(FUNC_TICK, 8'd0, 8'd0);
        write_reg(CFG_EXPIRY, 8'd1);
        write_reg(CFG_AGE_PERIOD, 8'd1);
        send_word(FUNC_MSG, 8'd9, 8'd3);
        send_word(FUNC_TICK, 8'd0, 8'd0);
        send_word(FUNC_TICK, 8'd0, 8'd0);
    endtask

    task automatic test_random_phase(input int n, input logic [3:0] ex, input logic [7:0] ap,
                                     input logic [7:0] bo, input logic [7:0] bp,
                                     input logic [7:0] ms, input logic [7:0] mp,
                                     input logic [7:0] su, input int tick_pct,
                                     input bit calm);
        write_all_regs(ex, ap, bo, bp, ms, mp, su);
        id_base = 8'($urandom_range(236));
        tx_calm = calm;
        rx_calm = calm;
        repeat (n) send_random_word(tick_pct);
        tx_calm = 1'b0;
        rx_calm = 1'b0;
    endtask

    task automatic test_random_settings(input int n);
        test_random_phase(n, 4'($urandom_range(1, 15)), 8'($urandom_range(1, 255)),
                          8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                          8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                          8'($urandom_range(0, 255)), $urandom_range(30, 60), 1'b0);
    endtask

    // receiver stops taking results while words keep coming, so the input stalls
    task automatic test_receiver_hold();
        rx_hold_req++;
        repeat (40) send_random_word(40);
    endtask

    task automatic test_sender_pause();
        repeat (20) send_random_word(40);
        wait_drained();
        repeat (20) send_random_word(40);
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = FUNC_MSG;
        cfg_valid = 1'b0;
        cfg_index = CFG_EXPIRY;
        cfg_data  = '0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_basic_words();
        test_table_full();
        test_instant_expiry();
        test_random_phase(100, 4'd2, 8'd1, 8'd3, 8'd5, 8'd4, 8'd7, 8'd0, 40, 1'b0);
        test_random_phase(100, 4'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 40, 1'b0);
        test_random_phase(100, 4'd15, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
                          50, 1'b0);
        // off point equal to the period: turning off wins
        test_random_phase(80, 4'd3, 8'd2, 8'd4, 8'd4, 8'd6, 8'd6, 8'd0, 45, 1'b0);
        test_random_phase(100, 4'd3, 8'd3, 8'd2, 8'd9, 8'd5, 8'd11, 8'd20, 45, 1'b1);
        test_random_settings(100);
        test_random_settings(100);
        test_random_phase(10, 4'd2, 8'd1, 8'd3, 8'd5, 8'd4, 8'd7, 8'd0, 40, 1'b0);
        test_receiver_hold();
        test_sender_pause();

        wait_drained();
        repeat (SETTLE) @(posedge aclk);
        if (pending_status.size() != 0)
            $display("%0t: %0d status words never arrived", $time, pending_status.size());
        if (errors == 0 && pending_status.size() == 0) begin
            $display("neighbor_table_with_heartbeat_expiry test passed");
        end else begin
            $display("neighbor_table_with_heartbeat_expiry test failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/ntbl_pkg.sv
sv/ntbl_mode.sv
sv/neighbor_table_with_heartbeat_expiry.sv
sv/ntbl_checker.sv
verif/neighbor_table_with_heartbeat_expiry_tb.sv
